// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/aes_cbc_pkg.sv =====
`timescale 1ns / 1ps
// types, constants and round functions for the aes-128 cbc encryptor
// no dependencies
package aes_cbc_pkg;

  typedef logic [127:0] blk_t;
  typedef logic [31:0]  word_t;

  localparam int unsigned NUM_ROUNDS = 10;
  localparam int unsigned NUM_WORDS  = 44;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_IV_HIGH  = 2'd2;
  localparam logic [1:0] REG_IV_LOW   = 2'd3;

  localparam logic [7:0] GF_POLY = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic word_t sub_word(input word_t w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte k of the state sits in bits 127-8k .. 120-8k
  function automatic blk_t sub_shift(input blk_t s);
    blk_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(c*4 + r) -: 8] = SBOX[s[127 - 8*((((c + r) % 4) * 4) + r) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic blk_t mix_columns(input blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 8] = a0 ^ al ^ gf_dbl(a0 ^ a1);
      t[119 - 32*c -: 8] = a1 ^ al ^ gf_dbl(a1 ^ a2);
      t[111 - 32*c -: 8] = a2 ^ al ^ gf_dbl(a2 ^ a3);
      t[103 - 32*c -: 8] = a3 ^ al ^ gf_dbl(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

endpackage

// ===== sv/aes_cbc_keyexp.sv =====
`timescale 1ns / 1ps
// aes-128 key schedule: registers the cipher key, expands all 11 round keys
// depends on aes_cbc_pkg
module aes_cbc_keyexp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      key_hi_we,
  input  logic                      key_lo_we,
  input  logic [63:0]               wdata,
  output aes_cbc_pkg::blk_t         rkeys [aes_cbc_pkg::NUM_ROUNDS + 1]
);
  import aes_cbc_pkg::*;

  logic [63:0] key_hi_r, key_lo_r;
  word_t       w [NUM_WORDS];
  logic [7:0]  rc [NUM_ROUNDS + 1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else begin
      if (key_hi_we) key_hi_r <= wdata;
      if (key_lo_we) key_lo_r <= wdata;
    end
  end

  // round keys follow the key registers; the user must keep the block idle while the key changes (not enforced here)
  always_comb begin
    rc[0] = 8'h01;
    for (int k = 1; k <= NUM_ROUNDS; k++) rc[k] = gf_dbl(rc[k-1]);
    w[0] = key_hi_r[63:32];
    w[1] = key_hi_r[31:0];
    w[2] = key_lo_r[63:32];
    w[3] = key_lo_r[31:0];
    for (int i = 4; i < NUM_WORDS; i++) begin
      if ((i % 4) == 0)
        w[i] = w[i-4] ^ sub_word({w[i-1][23:0], w[i-1][31:24]}) ^ {rc[i/4 - 1], 24'h0};
      else
        w[i] = w[i-4] ^ w[i-1];
    end
    for (int r = 0; r <= NUM_ROUNDS; r++)
      rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  end

endmodule

// ===== sv/aes_cbc_rounds.sv =====
`timescale 1ns / 1ps
// ten unrolled aes-128 rounds on one state
// depends on aes_cbc_pkg
module aes_cbc_rounds (
  input  aes_cbc_pkg::blk_t  state_in,
  input  aes_cbc_pkg::blk_t  rkeys [aes_cbc_pkg::NUM_ROUNDS + 1],
  output aes_cbc_pkg::blk_t  state_out
);
  import aes_cbc_pkg::*;

  blk_t st [NUM_ROUNDS + 1];

  always_comb begin
    st[0] = state_in ^ rkeys[0];
    for (int r = 1; r < NUM_ROUNDS; r++)
      st[r] = mix_columns(sub_shift(st[r-1])) ^ rkeys[r];
    st[NUM_ROUNDS] = sub_shift(st[NUM_ROUNDS-1]) ^ rkeys[NUM_ROUNDS];
    state_out = st[NUM_ROUNDS];
  end

endmodule

// ===== sv/aes128_cbc_encrypt.sv =====
// aes-128 cbc encryptor, one 128-bit beat in, one ciphertext beat out
// result: the ciphertext of an accepted input beat is in the result register in the cycle after
// throughput: one beat per cycle while out_stall does not hold a waiting result; all ten rounds sit between
//   the chain register and the result register, so the cbc feedback needs no register but the chain register
// reset: synchronous active-low rst_n clears key, iv and chain value to zero
`timescale 1ns / 1ps
module aes128_cbc_encrypt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_plain_high,
  input  logic [63:0] in_plain_low,
  input  logic        in_first_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_cipher_high,
  output logic [63:0] out_cipher_low
);
  import aes_cbc_pkg::*;

  logic [63:0] iv_hi_r, iv_lo_r;
  blk_t        chain_r, chain_nxt;
  blk_t        rkeys [NUM_ROUNDS + 1];
  blk_t        enc_out;
  blk_t        res_r;
  logic        res_valid_r;
  logic        in_acc, out_acc;

  assign out_acc  = res_valid_r && !out_stall;
  assign in_stall = res_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  aes_cbc_keyexp u_keyexp (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_hi_we (cfg_we && cfg_index == REG_KEY_HIGH),
    .key_lo_we (cfg_we && cfg_index == REG_KEY_LOW),
    .wdata     (cfg_wdata),
    .rkeys     (rkeys)
  );

  assign chain_nxt = in_first_block ? {iv_hi_r, iv_lo_r} : chain_r;

  aes_cbc_rounds u_rounds (
    .state_in  ({in_plain_high, in_plain_low} ^ chain_nxt),
    .rkeys     (rkeys),
    .state_out (enc_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_hi_r     <= '0;
      iv_lo_r     <= '0;
      chain_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_IV_HIGH) iv_hi_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_IV_LOW)  iv_lo_r <= cfg_wdata;
      if (in_acc) begin
        chain_r     <= enc_out;
        res_valid_r <= 1'b1;
      end else if (out_acc) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) res_r <= enc_out;
  end

  assign out_valid       = res_valid_r;
  assign out_cipher_high = res_r[127:64];
  assign out_cipher_low  = res_r[63:0];

endmodule

// ===== sv/aes_cbc_checker.sv =====
`timescale 1ns / 1ps
// port-level checker for the aes-128 cbc encryptor, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module aes_cbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_cipher_high,
  input logic [63:0] out_cipher_low
);

  `ASSERT_CLK(a_in_beat_gives_result, clk, rst_n, (in_valid && !in_stall) |=> out_valid, "accepted beat gave no result")
  `ASSERT_CLK(a_stall_only_when_full, clk, rst_n, in_stall |-> (out_valid && out_stall), "input stalled without a waiting result")
  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_cipher_high) && $stable(out_cipher_low)), "stalled result changed")
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind aes128_cbc_encrypt aes_cbc_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_cipher_high (out_cipher_high),
  .out_cipher_low  (out_cipher_low)
);

// ===== verif/tb_aes128_cbc_encrypt.sv =====
`timescale 1ns / 1ps
// self-checking bench for the aes-128 cbc encryptor: random and directed beats,
// a clocked driver and monitor, and an in-bench cipher model for the expected ciphertext
// depends on aes_cbc_pkg and aes128_cbc_encrypt
module tb_aes128_cbc_encrypt;
  import aes_cbc_pkg::*;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        first;
  } plain_beat_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_beat_t;

  localparam logic [7:0] S_TAB [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam int MAX_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_plain_high = '0;
  logic [63:0] in_plain_low = '0;
  logic        in_first_block = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_cipher_high;
  logic [63:0] out_cipher_low;

  aes128_cbc_encrypt dut (.*);

  always #5 clk = ~clk;

  // model state
  logic [63:0]  m_key [2];
  logic [63:0]  m_iv [2];
  logic [127:0] m_chain;
  logic [31:0]  m_rk [44];

  plain_beat_t  plain_q[$];
  cipher_beat_t cipher_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 0;
  bit in_taken = 0;

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] w);
    return {S_TAB[w[31:24]], S_TAB[w[23:16]], S_TAB[w[15:8]], S_TAB[w[7:0]]};
  endfunction

  task automatic rekey();
    logic [7:0]  rc;
    logic [31:0] t;
    rc = 8'h01;
    m_rk[0] = m_key[0][63:32];
    m_rk[1] = m_key[0][31:0];
    m_rk[2] = m_key[1][63:32];
    m_rk[3] = m_key[1][31:0];
    for (int i = 4; i < 44; i++) begin
      t = m_rk[i-1];
      if (i % 4 == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = xtime(rc);
      end
      m_rk[i] = m_rk[i-4] ^ t;
    end
  endtask

  // state byte k held in st[k], column-major
  function automatic logic [127:0] encrypt_block(logic [127:0] blk);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int k = 0; k < 16; k++) st[k] = blk[127-8*k -: 8];
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++) tmp[c*4+w] = S_TAB[st[((c+w)%4)*4+w]];
        st = tmp;
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[c*4]; a1 = st[c*4+1]; a2 = st[c*4+2]; a3 = st[c*4+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            st[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
            st[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
            st[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
            st[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) st[c*4+w] ^= m_rk[rnd*4+c][31-8*w -: 8];
    end
    for (int k = 0; k < 16; k++) r[127-8*k -: 8] = st[k];
    return r;
  endfunction

  task automatic predict_cipher(plain_beat_t p);
    cipher_beat_t e;
    if (p.first) m_chain = {m_iv[0], m_iv[1]};
    m_chain = encrypt_block({p.hi, p.lo} ^ m_chain);
    e.hi = m_chain[127:64];
    e.lo = m_chain[63:0];
    cipher_q.push_back(e);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (plain_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_plain_high <= plain_q[0].hi;
          in_plain_low <= plain_q[0].lo;
          in_first_block <= plain_q[0].first;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    in_taken = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      predict_cipher(plain_q.pop_front());
      in_taken = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (cipher_q.size() == 0) begin
        report_mismatch("unexpected beat", out_cipher_high, out_cipher_low);
      end else begin
        if (out_cipher_high !== cipher_q[0].hi)
          report_mismatch("cipher_high", out_cipher_high, cipher_q[0].hi);
        if (out_cipher_low !== cipher_q[0].lo)
          report_mismatch("cipher_low", out_cipher_low, cipher_q[0].lo);
        void'(cipher_q.pop_front());
      end
    end
    if (cycles > MAX_CYCLES) begin
      $display("tb_aes128_cbc_encrypt NOT OK");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] edge_val(int sel);
    case (sel)
      0: return 64'h0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h0000_0000_0000_0001;
      default: return rand64();
    endcase
  endfunction

  task automatic queue_plain(logic [63:0] hi, logic [63:0] lo, logic first);
    plain_beat_t p;
    p.hi = hi; p.lo = lo; p.first = first;
    plain_q.push_back(p);
  endtask

  task automatic drain();
    while (plain_q.size() > 0 || in_valid || cipher_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY_HIGH: begin m_key[0] = val; rekey(); end
      REG_KEY_LOW:  begin m_key[1] = val; rekey(); end
      REG_IV_HIGH:  m_iv[0] = val;
      default:      m_iv[1] = val;
    endcase
  endtask

  task automatic random_messages(int n);
    int left;
    left = n;
    while (left > 0) begin
      int len;
      len = $urandom_range(12, 1);
      for (int i = 0; i < len && left > 0; i++) begin
        // occasional stray first flag mid-message
        queue_plain(rand64(), rand64(), (i == 0) ? ($urandom_range(9) != 0)
                                                 : ($urandom_range(19) == 0));
        left--;
      end
    end
  endtask

  initial begin
    m_key[0] = '0; m_key[1] = '0; m_iv[0] = '0; m_iv[1] = '0;
    m_chain = '0;
    rekey();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero chain after reset, no first flag
    queue_plain(64'h0, 64'h0, 1'b0);
    queue_plain('1, '1, 1'b0);
    drain();
    write_reg(REG_KEY_HIGH, 64'h2b7e1516_28aed2a6);
    write_reg(REG_KEY_LOW,  64'habf71588_09cf4f3c);
    write_reg(REG_IV_HIGH,  64'h00010203_04050607);
    write_reg(REG_IV_LOW,   64'h08090a0b_0c0d0e0f);
    queue_plain(64'h6bc1bee2_2e409f96, 64'he93d7e11_7393172a, 1'b1);
    queue_plain(64'hae2d8a57_1e03ac9c, 64'h9eb76fac_45af8e51, 1'b0);
    for (int i = 0; i < 8; i++) queue_plain(edge_val(i % 4), edge_val(3 - i % 4), i[0]);
    drain();
    // iv change mid-message, then key change mid-message keeping the chain
    write_reg(REG_IV_HIGH, '1);
    write_reg(REG_IV_LOW, '1);
    queue_plain(rand64(), rand64(), 1'b0);
    queue_plain(rand64(), rand64(), 1'b1);
    drain();
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '1);
    queue_plain(rand64(), rand64(), 1'b0);
    queue_plain('1, 64'h0, 1'b0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      for (int r = 0; r < 4; r++)
        write_reg(r[1:0], (ph == 0) ? 64'h0 : (ph == 1) ? '1 : rand64());
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        3: begin send_idle_pct = 30; recv_stall_pct = 30; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 4) recv_hold = 1;
      random_messages(200);
      if (ph == 4) begin
        repeat (300) @(posedge clk);
        recv_hold = 0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb_aes128_cbc_encrypt OK");
    end else begin
      $display("tb_aes128_cbc_encrypt NOT OK");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/aes_cbc_pkg.sv
sv/aes_cbc_keyexp.sv
sv/aes_cbc_rounds.sv
sv/aes128_cbc_encrypt.sv
sv/aes_cbc_checker.sv
verif/tb_aes128_cbc_encrypt.sv
